// File: src/nlc_pkg.sv
// Package for the numeric literal classifier: state type, mode and class codes,
// and the character test functions. No dependencies.
package nlc_pkg;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_ZERO  = 3'd1;
    localparam logic [2:0] MODE_OCT   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_DEC   = 3'd4;
    localparam logic [2:0] MODE_FLT   = 3'd5;

    localparam logic [2:0] CLASS_ZERO = 3'd0;
    localparam logic [2:0] CLASS_OCT  = 3'd1;
    localparam logic [2:0] CLASS_HEX  = 3'd2;
    localparam logic [2:0] CLASS_DEC  = 3'd3;
    localparam logic [2:0] CLASS_FLT  = 3'd4;
    localparam logic [2:0] CLASS_MAL  = 3'd5;

    localparam logic [1:0] POS_MAX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [1:0] position;
        logic [2:0] mode;
        logic       marker_is_exponent;
        logic       need_digit_or_sign;
        logic       digit_after_marker;
        logic       bad;
    } t_state;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= CH_LC_A) && (c <= CH_LC_F))
            || ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == CH_LC_E) || (c == CH_UC_E);
    endfunction

    function automatic logic is_marker(input logic [7:0] c);
        return (c == CH_DOT) || is_exp(c);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

// File: src/numeric_literal_classifier_core.sv
// Top level of the numeric literal classifier: input register, token state, result register.
// Depends on nlc_pkg and nlc_step.
//
//  Channel | Dir | Beat                       | Fields (tdata low bit up)
//  s       | in  | one token character        | tdata[7:0] ch, tlast = last
//  m       | out | one class per token        | tdata[2:0] token_class, [7:3] zero
//
// A character is taken every cycle unless a last beat waits on a stalled result.
// The combinational step links the input register to the token state and result registers.
// Reset clears the token state and both valid flags; it is synchronous and active low.
// A stalled result holds last beats, and a held last beat blocks all characters behind it.
module numeric_literal_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [2:0] token_class, [7:3] zero
);
    import nlc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;
    t_state     r_state;
    logic       r_out_valid;
    logic [2:0] r_out_class;

    t_state     step_next;
    logic [2:0] step_class;
    logic       advance;

    nlc_step u_step (
        .i_state (r_state),
        .i_ch    (r_in_ch),
        .o_next  (step_next),
        .o_class (step_class)
    );

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_class};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= r_in_last ? t_state'('0) : step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_class <= step_class;
        end
    end

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state == t_state'('0))
        else $error("Token state not cleared after a last beat.");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode <= MODE_FLT)
        else $error("Token mode outside its codes.");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_class <= CLASS_MAL)
        else $error("Result class outside its codes.");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_last))
        else $error("Result raised without a last beat.");

    a_held_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_ch) && $stable(r_in_last))
        else $error("Blocked character lost from the input register.");

endmodule

// File: src/nlc_step.sv
// One character step of the classifier: next token state and the class on the last beat.
// Pure combinational logic; depends on nlc_pkg.
module nlc_step (
    input  nlc_pkg::t_state i_state,
    input  logic [7:0]      i_ch,
    output nlc_pkg::t_state o_next,
    output logic [2:0]      o_class
);
    import nlc_pkg::*;

    t_state s;

    always_comb begin
        s = i_state;
        if (!i_state.bad) begin
            case (i_state.mode)
                MODE_START: begin
                    if (i_ch == CH_ZERO) begin
                        s.mode = MODE_ZERO;
                    end else if (is_dig(i_ch)) begin
                        s.mode = MODE_DEC;
                    end else begin
                        s.bad = 1'b1;
                    end
                end
                MODE_ZERO: begin
                    if (is_oct(i_ch)) begin
                        s.mode = MODE_OCT;
                    end else if ((i_ch == CH_LC_X) || (i_ch == CH_UC_X)) begin
                        s.mode = MODE_HEX;
                    end else if (i_ch == CH_DOT) begin
                        s.mode               = MODE_FLT;
                        s.marker_is_exponent = 1'b0;
                        s.need_digit_or_sign = 1'b1;
                        s.digit_after_marker = 1'b0;
                    end else begin
                        s.bad = 1'b1;
                    end
                end
                MODE_OCT: begin
                    if (!is_oct(i_ch)) s.bad = 1'b1;
                end
                MODE_HEX: begin
                    if (!is_hex(i_ch)) s.bad = 1'b1;
                end
                MODE_DEC: begin
                    if (is_marker(i_ch)) begin
                        s.mode               = MODE_FLT;
                        s.marker_is_exponent = is_exp(i_ch);
                        s.need_digit_or_sign = 1'b1;
                        s.digit_after_marker = 1'b0;
                    end else if (!is_dig(i_ch)) begin
                        s.bad = 1'b1;
                    end
                end
                MODE_FLT: begin
                    if (i_state.need_digit_or_sign) begin
                        if (!is_dig(i_ch) && !is_sign(i_ch)) s.bad = 1'b1;
                        s.need_digit_or_sign = 1'b0;
                    end
                    if (is_dig(i_ch)) s.digit_after_marker = 1'b1;
                    if (i_state.marker_is_exponent && (i_ch == CH_DOT)) s.bad = 1'b1;
                end
                default: begin
                    s.bad = 1'b1;
                end
            endcase
        end
        if (i_state.position != POS_MAX) s.position = i_state.position + 2'd1;
        o_next = s;
    end

    always_comb begin
        if (s.bad) begin
            o_class = CLASS_MAL;
        end else begin
            case (s.mode)
                MODE_ZERO: o_class = CLASS_ZERO;
                MODE_OCT:  o_class = CLASS_OCT;
                MODE_HEX:  o_class = (s.position == POS_MAX) ? CLASS_HEX : CLASS_MAL;
                MODE_DEC:  o_class = CLASS_DEC;
                MODE_FLT: begin
                    if (is_marker(i_ch) || is_sign(i_ch) || s.need_digit_or_sign
                        || !s.digit_after_marker) begin
                        o_class = CLASS_MAL;
                    end else begin
                        o_class = CLASS_FLT;
                    end
                end
                default:   o_class = CLASS_MAL;
            endcase
        end
    end

endmodule

// File: tb/sv/nlc_class_checker.sv
`timescale 1ns / 100ps
// Scoreboard for numeric_literal_classifier_core: watches both stream channels, predicts
// each token's class from its character beats and checks every result beat against it.
// Depends on nlc_pkg for the mode, class and character codes.
module nlc_class_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [2:0] token_class, [7:3] zero
    output int         o_fail_count,
    output int         o_pending
);
    import nlc_pkg::*;

    logic [2:0] class_q[$];
    logic [1:0] chars_seen;
    logic [2:0] lit_mode;
    logic       exp_marker;
    logic       want_digit_or_sign;
    logic       digit_seen;
    logic       malformed;
    logic [7:0] want_beat;
    int         fail_cnt = 0;
    int         pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic logic char_between(input logic [7:0] c, input logic [7:0] lo,
                                          input logic [7:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic char_digit(input logic [7:0] c);
        return char_between(c, CH_ZERO, CH_NINE);
    endfunction

    function automatic logic char_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic char_marker(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_LC_E) || (c == CH_UC_E);
    endfunction

    task automatic clear_token();
        chars_seen         = 2'd0;
        lit_mode           = MODE_START;
        exp_marker         = 1'b0;
        want_digit_or_sign = 1'b0;
        digit_seen         = 1'b0;
        malformed          = 1'b0;
    endtask

    task automatic start_fraction(input logic [7:0] c);
        lit_mode           = MODE_FLT;
        exp_marker         = (c == CH_LC_E) || (c == CH_UC_E);
        want_digit_or_sign = 1'b1;
        digit_seen         = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        if (!malformed) begin
            case (lit_mode)
                MODE_START: begin
                    if (c == CH_ZERO) lit_mode = MODE_ZERO;
                    else if (char_digit(c)) lit_mode = MODE_DEC;
                    else malformed = 1'b1;
                end
                MODE_ZERO: begin
                    if (char_between(c, CH_ZERO, CH_SEVEN)) lit_mode = MODE_OCT;
                    else if ((c == CH_LC_X) || (c == CH_UC_X)) lit_mode = MODE_HEX;
                    else if (c == CH_DOT) start_fraction(c);
                    else malformed = 1'b1;
                end
                MODE_OCT: begin
                    if (!char_between(c, CH_ZERO, CH_SEVEN)) malformed = 1'b1;
                end
                MODE_HEX: begin
                    if (!(char_digit(c) || char_between(c, CH_LC_A, CH_LC_F)
                          || char_between(c, CH_UC_A, CH_UC_F))) malformed = 1'b1;
                end
                MODE_DEC: begin
                    if (char_marker(c)) start_fraction(c);
                    else if (!char_digit(c)) malformed = 1'b1;
                end
                MODE_FLT: begin
                    if (want_digit_or_sign) begin
                        if (!char_digit(c) && !char_sign(c)) malformed = 1'b1;
                        want_digit_or_sign = 1'b0;
                    end
                    if (char_digit(c)) digit_seen = 1'b1;
                    if (exp_marker && (c == CH_DOT)) malformed = 1'b1;
                end
                default: malformed = 1'b1;
            endcase
        end
        if (chars_seen != POS_MAX) chars_seen = chars_seen + 2'd1;
    endtask

    function automatic logic [2:0] token_verdict(input logic [7:0] c);
        if (malformed) return CLASS_MAL;
        case (lit_mode)
            MODE_ZERO: return CLASS_ZERO;
            MODE_OCT:  return CLASS_OCT;
            MODE_HEX:  return (chars_seen == POS_MAX) ? CLASS_HEX : CLASS_MAL;
            MODE_DEC:  return CLASS_DEC;
            MODE_FLT: begin
                if (char_marker(c) || char_sign(c)) return CLASS_MAL;
                if (want_digit_or_sign || !digit_seen) return CLASS_MAL;
                return CLASS_FLT;
            end
            default:   return CLASS_MAL;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            class_q.delete();
            clear_token();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (class_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: class beat %0d with no token pending", $time, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want_beat = {5'd0, class_q.pop_front()};
                    if (i_m_tdata != want_beat) begin
                        if (fail_cnt < 10)
                            $display("%0t: class mismatch, expected %0d got %0d",
                                     $time, want_beat, i_m_tdata);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_char(i_s_tdata);
                if (i_s_tlast) begin
                    class_q.push_back(token_verdict(i_s_tdata));
                    clear_token();
                end
            end
        end
        pending_cnt = class_q.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the numeric literal classifier testbench: clock, reset, token stimulus with
// varying input gaps and result back-pressure, and the verdict. Depends on nlc_pkg,
// numeric_literal_classifier_core and nlc_class_checker.
module tb;
    import nlc_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] ch
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [2:0] token_class, [7:3] zero
    int         fail_count;
    int         pending;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         rx_hold_len = 0;
    int         chars_sent = 0;
    logic [7:0] tok_q[$];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    numeric_literal_classifier_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    nlc_class_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : result_side
        int held;
        forever begin
            @(posedge clk);
            if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                for (held = 0; held < rx_hold_len; held++) @(posedge clk);
                rx_hold_len = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [7:0] digit_ch();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] oct_ch();
        return CH_ZERO + 8'($urandom_range(7));
    endfunction

    function automatic logic [7:0] hex_ch();
        case ($urandom_range(2))
            0:       return digit_ch();
            1:       return CH_LC_A + 8'($urandom_range(5));
            default: return CH_UC_A + 8'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] marker_ch();
        case ($urandom_range(2))
            0:       return CH_DOT;
            1:       return CH_LC_E;
            default: return CH_UC_E;
        endcase
    endfunction

    function automatic logic [7:0] fraction_tail_ch();
        case ($urandom_range(9))
            0:       return marker_ch();
            1:       return ($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS;
            2:       return 8'($urandom_range(255));
            default: return digit_ch();
        endcase
    endfunction

    task automatic build_good(input int kind);
        tok_q.delete();
        case (kind)
            0: tok_q.push_back(CH_ZERO);
            1: begin
                tok_q.push_back(CH_ZERO);
                repeat ($urandom_range(1, 6)) tok_q.push_back(oct_ch());
            end
            2: begin
                tok_q.push_back(CH_ZERO);
                tok_q.push_back(($urandom_range(1) != 0) ? CH_LC_X : CH_UC_X);
                repeat ($urandom_range(1, 5)) tok_q.push_back(hex_ch());
            end
            3: begin
                tok_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(0, 5)) tok_q.push_back(digit_ch());
            end
            default: begin
                if ($urandom_range(3) == 0) begin
                    tok_q.push_back(CH_ZERO);
                    tok_q.push_back(CH_DOT);
                end else begin
                    tok_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                    repeat ($urandom_range(0, 3)) tok_q.push_back(digit_ch());
                    tok_q.push_back(marker_ch());
                end
                if ($urandom_range(3) == 0)
                    tok_q.push_back(($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS);
                else
                    tok_q.push_back(digit_ch());
                repeat ($urandom_range(0, 4)) tok_q.push_back(fraction_tail_ch());
                tok_q.push_back(digit_ch());
            end
        endcase
    endtask

    task automatic build_token(input int kind);
        if (kind <= 6) begin
            build_good(kind);
        end else if (kind == 7) begin
            tok_q.delete();
            repeat ($urandom_range(1, 6)) tok_q.push_back(8'($urandom_range(255)));
        end else if (kind == 8) begin
            build_good($urandom_range(1, 5));
            tok_q[$urandom_range(tok_q.size() - 1)] = 8'($urandom_range(255));
        end else begin
            build_good($urandom_range(1, 5));
            if (tok_q.size() > 1) void'(tok_q.pop_back());
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_token();
        for (int i = 0; i < tok_q.size(); i++) send_char(tok_q[i], i == tok_q.size() - 1);
    endtask

    task automatic send_text(input string txt);
        tok_q.delete();
        for (int i = 0; i < txt.len(); i++) tok_q.push_back(txt[i]);
        send_token();
    endtask

    task automatic wait_all_classes();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) begin
            build_token($urandom_range(9));
            send_token();
        end
        wait_all_classes();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0");
        send_text("07");
        send_text("0xf");
        send_text("9");
        send_text("1.5");
        send_text("1e-5");
        send_text("a");
        send_text("08");
        send_text("0e");
        send_text("0x");
        send_text("1e.");
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        wait_all_classes();

        run_phase(25, 82, 250);
        run_phase(82, 25, 250);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 120;
        repeat (40) begin
            build_token($urandom_range(1) != 0 ? 0 : 3);
            send_token();
        end
        wait_all_classes();

        run_phase(0, 0, 250);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
src/nlc_pkg.sv
src/nlc_step.sv
src/numeric_literal_classifier_core.sv
tb/sv/nlc_class_checker.sv
tb/sv/tb.sv
